@@ rtl/jptc_pkg.sv @@
package jptc_pkg;

   localparam int JOINT_COUNT_DEF = 12;
   localparam int ONE_Q16 = 65536;

   typedef enum logic [1:0] {
      CMD_SAMPLE = 2'd0,
      CMD_STAND  = 2'd1,
      CMD_LIE    = 2'd2,
      CMD_DAMP   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      MODE_DAMPING    = 2'd0,
      MODE_HOLD       = 2'd1,
      MODE_TRAJECTORY = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      ACT_DAMPING = 2'd0,
      ACT_LIE     = 2'd1,
      ACT_STAND   = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      REG_MAX_STEP   = 2'd0,
      REG_MAX_TRACK  = 2'd1,
      REG_PROG_STEP  = 2'd2,
      REG_DAMP_GAIN  = 2'd3
   } reg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SAMPLE,
      ST_POSE,
      ST_ERR,
      ST_PROG,
      ST_SQ,
      ST_SMOOTH,
      ST_MUL,
      ST_REF,
      ST_CLAMP,
      ST_DONE,
      ST_EMIT,
      ST_FAULT
   } state_type;

   typedef struct packed {
      cmd_type     command;
      logic [1:0]  limb;
      logic [1:0]  joint;
      logic [15:0] observed_position;
      logic        last_of_tick;
   } item_type;

   typedef struct packed {
      logic [1:0]  out_limb;
      logic [1:0]  out_joint;
      logic [15:0] command_position;
      logic [15:0] stiffness_gain;
      logic [15:0] velocity_gain;
      logic [1:0]  action;
      logic        holding;
      logic        fault;
      logic        last;
   } result_type;

   function automatic logic signed [15:0] pose_value(logic lying, logic [1:0] limb,
                                                     logic [1:0] joint);
      logic signed [15:0] v;
      v = 16'sd0;
      if (!lying) begin
         unique case (joint)
            2'd0: v = 16'sd0;
            2'd1: v = 16'sd3277;
            default: v = -16'sd6144;
         endcase
      end else begin
         unique case (joint)
            2'd0: v = limb[0] ? -16'sd1966 : 16'sd1966;
            2'd1: v = 16'sd4506;
            default: v = -16'sd11141;
         endcase
      end
      return v;
   endfunction

endpackage

@@ rtl/jptc_front.sv @@
module jptc_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  jptc_pkg::item_type  in_item,
   output logic                q_valid,
   input  logic                q_ready,
   output jptc_pkg::item_type  q_item
);
   import jptc_pkg::*;

   localparam int DEPTH = 2;

   item_type   buf_ff [DEPTH];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign in_ready = (cnt_ff != 2'(DEPTH));
   assign q_valid  = (cnt_ff != 2'd0);
   assign q_item   = buf_ff[rp_ff];
   assign push     = in_valid && in_ready;
   assign pop      = q_valid && q_ready;

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) buf_ff[wp_ff] <= in_item;
   end
endmodule

@@ rtl/jptc_back.sv @@
module jptc_back #(
   parameter int JOINT_COUNT = jptc_pkg::JOINT_COUNT_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   output logic                 q_ready,
   input  jptc_pkg::item_type   q_item,
   input  logic [12:0]          max_step,
   input  logic [12:0]          max_track,
   input  logic [16:0]          prog_step,
   input  logic [15:0]          damp_gain,
   output logic                 out_valid,
   input  logic                 out_ready,
   output jptc_pkg::result_type out_item
);
   import jptc_pkg::*;

   localparam int SW = $clog2(JOINT_COUNT);

   logic signed [15:0] obs_ff [JOINT_COUNT];
   logic signed [15:0] start_ff [JOINT_COUNT];
   logic signed [15:0] targ_ff [JOINT_COUNT];
   logic signed [15:0] setp_ff [JOINT_COUNT];

   state_type   state_ff, state_in;
   mode_type    mode_ff, mode_in;
   logic [JOINT_COUNT-1:0] seen_ff, seen_in;
   logic [16:0] prog_ff, prog_in;
   logic        lying_ff, lying_in, have_ff, have_in;
   logic [SW-1:0] idx_ff, idx_in;
   logic [1:0]  limb_ff, limb_in, jnt_ff, jnt_in;
   logic [16:0] worst_ff, worst_in;
   logic [16:0] sq_ff, sq_in;
   logic [16:0] smooth_ff, smooth_in;
   logic [33:0] mag_ff, mag_in;
   logic signed [17:0] ref_ff, ref_in;
   logic        neg_ff, neg_in, clamped_ff, clamped_in;
   logic        ov_ff, ov_in;
   result_type  res_ff, res_in;

   logic [SW-1:0] slot;
   logic signed [16:0] d_err, d_td;
   logic [16:0] a_err, a_td;
   logic [33:0] p2full, smfull;
   logic [17:0] three_m;
   logic signed [17:0] lo, hi, nx;
   logic        wr_obs, wr_pose, wr_setp;
   logic signed [15:0] setp_val;
   logic        damp;
   logic [16:0] psum;

   assign slot     = SW'(q_item.limb * 2'd3 + {2'b00, q_item.joint} * 1'b1);
   assign d_err    = 17'(obs_ff[idx_ff]) - 17'(setp_ff[idx_ff]);
   assign a_err    = d_err[16] ? 17'(-d_err) : 17'(d_err);
   assign d_td     = 17'(targ_ff[idx_ff]) - 17'(start_ff[idx_ff]);
   assign a_td     = d_td[16] ? 17'(-d_td) : 17'(d_td);
   assign p2full   = prog_ff * prog_ff + 34'd32768;
   assign three_m  = 18'(3 * ONE_Q16) - {prog_ff, 1'b0};
   assign smfull   = 34'(sq_ff * three_m + 34'd32768);
   assign lo       = 18'(setp_ff[idx_ff]) - 18'(max_step);
   assign hi       = 18'(setp_ff[idx_ff]) + 18'(max_step);
   assign nx       = (ref_ff < lo) ? lo : ((ref_ff > hi) ? hi : ref_ff);
   assign psum     = (18'(prog_ff) + 18'(prog_step) > 18'(ONE_Q16)) ? 17'(ONE_Q16)
                     : 17'(prog_ff + prog_step);
   assign damp     = (mode_ff == MODE_DAMPING);
   assign out_valid = ov_ff;
   assign out_item  = res_ff;

   always_comb begin
      state_in = state_ff; mode_in = mode_ff; seen_in = seen_ff; prog_in = prog_ff;
      lying_in = lying_ff; have_in = have_ff; idx_in = idx_ff;
      limb_in = limb_ff; jnt_in = jnt_ff; worst_in = worst_ff; sq_in = sq_ff;
      smooth_in = smooth_ff; mag_in = mag_ff; ref_in = ref_ff; neg_in = neg_ff;
      clamped_in = clamped_ff; ov_in = ov_ff; res_in = res_ff;
      q_ready = 1'b0; wr_obs = 1'b0; wr_pose = 1'b0; wr_setp = 1'b0;
      setp_val = 16'(nx);
      if (ov_ff && out_ready) ov_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            q_ready = 1'b1;
            if (q_valid) begin
               unique case (q_item.command)
                  CMD_SAMPLE: begin
                     if (q_item.joint != 2'd3) begin
                        wr_obs = 1'b1;
                        seen_in = seen_ff | (JOINT_COUNT'(1) << slot);
                     end
                     if (q_item.last_of_tick) state_in = ST_SAMPLE;
                  end
                  CMD_DAMP: mode_in = MODE_DAMPING;
                  default: if (have_ff) begin
                     lying_in = (q_item.command == CMD_LIE);
                     prog_in = 17'd0;
                     mode_in = MODE_TRAJECTORY;
                     idx_in = '0; limb_in = 2'd0; jnt_in = 2'd0;
                     state_in = ST_POSE;
                  end
               endcase
            end
         end
         ST_SAMPLE: begin
            if (seen_ff != {JOINT_COUNT{1'b1}}) begin
               seen_in = '0; mode_in = MODE_DAMPING; state_in = ST_FAULT;
            end else begin
               seen_in = '0; have_in = 1'b1;
               idx_in = '0; limb_in = 2'd0; jnt_in = 2'd0; worst_in = '0;
               state_in = (mode_ff == MODE_TRAJECTORY) ? ST_ERR : ST_EMIT;
            end
         end
         ST_POSE: begin
            wr_pose = 1'b1;
            if (32'(idx_ff) == JOINT_COUNT - 1) state_in = ST_IDLE;
            else begin
               idx_in = idx_ff + 1'b1;
               if (jnt_ff == 2'd2) begin jnt_in = 2'd0; limb_in = limb_ff + 1'b1; end
               else jnt_in = jnt_ff + 1'b1;
            end
         end
         ST_ERR: begin
            if (a_err > worst_ff) worst_in = a_err;
            if (32'(idx_ff) == JOINT_COUNT - 1) state_in = ST_PROG;
            else idx_in = idx_ff + 1'b1;
         end
         ST_PROG: begin
            idx_in = '0; limb_in = 2'd0; jnt_in = 2'd0;
            if (worst_ff > 17'(max_track)) state_in = ST_EMIT;
            else begin prog_in = psum; state_in = ST_SQ; end
         end
         ST_SQ: begin sq_in = p2full[32:16]; state_in = ST_SMOOTH; end
         ST_SMOOTH: begin
            smooth_in = smfull[32:16]; clamped_in = 1'b0; state_in = ST_MUL;
         end
         ST_MUL: begin
            mag_in = a_td * smooth_ff; neg_in = d_td[16]; state_in = ST_REF;
         end
         ST_REF: begin
            ref_in = 18'(start_ff[idx_ff]) +
                     (neg_ff ? -18'((mag_ff + 34'd32768) >> 16)
                             : 18'((mag_ff + 34'd32768) >> 16));
            state_in = ST_CLAMP;
         end
         ST_CLAMP: begin
            wr_setp = 1'b1;
            if (nx != ref_ff) clamped_in = 1'b1;
            if (32'(idx_ff) == JOINT_COUNT - 1) state_in = ST_DONE;
            else begin idx_in = idx_ff + 1'b1; state_in = ST_MUL; end
         end
         ST_DONE: begin
            if (prog_ff >= 17'(ONE_Q16) && !clamped_ff) mode_in = MODE_HOLD;
            idx_in = '0; limb_in = 2'd0; jnt_in = 2'd0;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!ov_ff || out_ready) begin
               ov_in = 1'b1;
               res_in.out_limb = limb_ff;
               res_in.out_joint = jnt_ff;
               res_in.command_position = damp ? obs_ff[idx_ff] : setp_ff[idx_ff];
               res_in.stiffness_gain = damp ? 16'd0 : (!limb_ff[1] ? 16'd23040 :
                                       (jnt_ff == 2'd2 ? 16'd35840 : 16'd33280));
               res_in.velocity_gain = damp ? damp_gain : (!limb_ff[1] ? 16'd384 : 16'd640);
               res_in.action = damp ? ACT_DAMPING : (lying_ff ? ACT_LIE : ACT_STAND);
               res_in.holding = (mode_ff == MODE_HOLD);
               res_in.fault = 1'b0;
               res_in.last = (32'(idx_ff) == JOINT_COUNT - 1);
               if (32'(idx_ff) == JOINT_COUNT - 1) state_in = ST_IDLE;
               else begin
                  idx_in = idx_ff + 1'b1;
                  if (jnt_ff == 2'd2) begin jnt_in = 2'd0; limb_in = limb_ff + 1'b1; end
                  else jnt_in = jnt_ff + 1'b1;
               end
            end
         end
         ST_FAULT: begin
            if (!ov_ff || out_ready) begin
               ov_in = 1'b1;
               res_in = '0;
               res_in.velocity_gain = damp_gain;
               res_in.fault = 1'b1;
               res_in.last = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; mode_ff <= MODE_DAMPING; seen_ff <= '0;
         prog_ff <= '0; lying_ff <= 1'b0; have_ff <= 1'b0; ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in; mode_ff <= mode_in; seen_ff <= seen_in;
         prog_ff <= prog_in; lying_ff <= lying_in; have_ff <= have_in; ov_ff <= ov_in;
      end
      idx_ff <= idx_in; limb_ff <= limb_in; jnt_ff <= jnt_in; worst_ff <= worst_in;
      sq_ff <= sq_in; smooth_ff <= smooth_in; mag_ff <= mag_in; ref_ff <= ref_in;
      neg_ff <= neg_in; clamped_ff <= clamped_in; res_ff <= res_in;
      if (wr_obs) obs_ff[slot] <= q_item.observed_position;
      if (wr_pose) begin
         start_ff[idx_ff] <= obs_ff[idx_ff];
         setp_ff[idx_ff]  <= obs_ff[idx_ff];
         targ_ff[idx_ff]  <= pose_value(lying_ff, limb_ff, jnt_ff);
      end
      if (wr_setp) setp_ff[idx_ff] <= setp_val;
   end
endmodule

@@ rtl/joint_pose_trajectory_controller_unit.sv @@
// A sample word is stored once the idle back end takes it. A tick-ending sample
// gives its first command after the sample check in damping or hold mode, after
// the error scan when progress is frozen, and in trajectory mode after the error
// scan, progress, square and smoothstep setup and a multiply, round and clamp
// step per joint. Throughput: one command word per cycle unless rsp_tready stalls.
// Pose commands load joint by joint. Reset is synchronous, active high.
module joint_pose_trajectory_controller_unit #(
   parameter int JOINT_COUNT = jptc_pkg::JOINT_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // command, limb, joint, observed_position
   input  logic        req_tlast,  // last_of_tick
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,  // out_limb, out_joint, command_position,
                                   // stiffness_gain, velocity_gain, action, holding, fault
   output logic        rsp_tlast,  // last
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [16:0] csr_wdata
);
   import jptc_pkg::*;

   logic [12:0] max_step_ff, max_track_ff;
   logic [16:0] prog_step_ff;
   logic [15:0] damp_gain_ff;
   item_type    in_item, q_item;
   logic        q_valid, q_ready;
   result_type  res;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_step_ff <= 13'd1024; max_track_ff <= 13'd1024;
         prog_step_ff <= 17'd655; damp_gain_ff <= 16'd640;
      end else if (csr_we) begin
         unique case (reg_type'(csr_index))
            REG_MAX_STEP:  max_step_ff  <= csr_wdata[12:0];
            REG_MAX_TRACK: max_track_ff <= csr_wdata[12:0];
            REG_PROG_STEP: prog_step_ff <= csr_wdata;
            REG_DAMP_GAIN: damp_gain_ff <= csr_wdata[15:0];
         endcase
      end
   end

   always_comb begin
      in_item.command = cmd_type'(req_tdata[1:0]);
      in_item.limb = req_tdata[3:2];
      in_item.joint = req_tdata[5:4];
      in_item.observed_position = req_tdata[21:6];
      in_item.last_of_tick = req_tlast;
   end

   jptc_front u_front (
      .clock(clock), .reset(reset), .in_valid(req_tvalid), .in_ready(req_tready),
      .in_item(in_item), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
   );

   jptc_back #(.JOINT_COUNT(JOINT_COUNT)) u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_ready(q_ready),
      .q_item(q_item), .max_step(max_step_ff), .max_track(max_track_ff),
      .prog_step(prog_step_ff), .damp_gain(damp_gain_ff),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_item(res)
   );

   assign rsp_tdata = {res.fault, res.holding, res.action, res.velocity_gain,
                       res.stiffness_gain, res.command_position, res.out_joint,
                       res.out_limb};
   assign rsp_tlast = res.last;
endmodule

@@ rtl/jptc_checker.sv @@
module jptc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic        rsp_tlast
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp word changed under stall");
   a_fault_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[55] |-> rsp_tlast)
      else $error("fault word not last");
   a_damp_stiff: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[53:52] == 2'd0 |-> rsp_tdata[35:20] == 16'd0)
      else $error("damping word with stiffness");
   a_hold_act: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[54] |-> rsp_tdata[53:52] != 2'd0)
      else $error("holding while damping");
endmodule

bind joint_pose_trajectory_controller_unit jptc_checker u_checker (
   .clock(clock), .reset(reset), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
);

@@ bench/joint_pose_trajectory_controller_unit_test.sv @@
`timescale 1ns / 1ps

module joint_pose_trajectory_controller_unit_test;
   import jptc_pkg::*;

   localparam int NJ = 12;
   localparam int DRAIN_CYCLES = 120;
   localparam int STALL_LIMIT = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [16:0] csr_wdata = '0;

   joint_pose_trajectory_controller_unit DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // controller mirror
   int        obs_pos[NJ];
   int        start_pos[NJ];
   int        goal_pos[NJ];
   int        set_pos[NJ];
   int        seen_bits;
   longint    prog;
   mode_type  ctl_mode;
   bit        lying;
   bit        observed_once;
   int        step_lim, track_lim, prog_inc, damp_gain;

   result_type pending_cmds[$];
   int errors = 0;
   int words_sent = 0;
   int send_idle = 15;
   int recv_idle = 59;
   int quiet_cycles = 0;

   function automatic int sx16(logic [15:0] v);
      return int'($signed(v));
   endfunction

   function automatic int pose_target(bit ly, int limb, int joint);
      if (!ly) return (joint == 0) ? 0 : (joint == 1) ? 3277 : -6144;
      if (joint == 0) return (limb == 1 || limb == 3) ? -1966 : 1966;
      return (joint == 1) ? 4506 : -11141;
   endfunction

   function automatic void step_trajectory();
      longint worst, a, p, p2, smooth, d, r, refp, lo, hi, nx;
      bit clamped;
      worst = 0;
      clamped = 0;
      for (int i = 0; i < NJ; i++) begin
         a = obs_pos[i] - set_pos[i];
         if (a < 0) a = -a;
         if (a > worst) worst = a;
      end
      if (worst > track_lim) return;
      p = prog + prog_inc;
      if (p > ONE_Q16) p = ONE_Q16;
      prog = p;
      p2 = (p * p + 32768) >>> 16;
      smooth = (p2 * (3 * ONE_Q16 - 2 * p) + 32768) >>> 16;
      for (int i = 0; i < NJ; i++) begin
         d = goal_pos[i] - start_pos[i];
         r = (((d < 0) ? -d : d) * smooth + 32768) >>> 16;
         refp = start_pos[i] + ((d < 0) ? -r : r);
         lo = set_pos[i] - step_lim;
         hi = set_pos[i] + step_lim;
         nx = (refp < lo) ? lo : (refp > hi) ? hi : refp;
         if (nx != refp) clamped = 1;
         set_pos[i] = int'(nx);
      end
      if (prog >= ONE_Q16 && !clamped) ctl_mode = MODE_HOLD;
   endfunction

   function automatic void predict_word(cmd_type cmd, int limb, int joint, logic [15:0] pos,
                                        bit lastw);
      result_type r;
      bit damp;
      if (cmd == CMD_SAMPLE) begin
         if (joint < 3) begin
            obs_pos[limb * 3 + joint] = sx16(pos);
            seen_bits |= 1 << (limb * 3 + joint);
         end
         if (!lastw) return;
         if (seen_bits != (1 << NJ) - 1) begin
            seen_bits = 0;
            ctl_mode = MODE_DAMPING;
            r = '0;
            r.velocity_gain = 16'(damp_gain);
            r.fault = 1'b1;
            r.last = 1'b1;
            pending_cmds.push_back(r);
            return;
         end
         seen_bits = 0;
         observed_once = 1;
         if (ctl_mode == MODE_TRAJECTORY) step_trajectory();
         damp = (ctl_mode == MODE_DAMPING);
         for (int i = 0; i < NJ; i++) begin
            r.out_limb = 2'(i / 3);
            r.out_joint = 2'(i % 3);
            r.command_position = 16'(damp ? obs_pos[i] : set_pos[i]);
            r.stiffness_gain = damp ? 16'd0 : (i < 6) ? 16'd23040 :
                               (i % 3 == 2) ? 16'd35840 : 16'd33280;
            r.velocity_gain = damp ? 16'(damp_gain) : (i < 6) ? 16'd384 : 16'd640;
            r.action = damp ? ACT_DAMPING : lying ? ACT_LIE : ACT_STAND;
            r.holding = (ctl_mode == MODE_HOLD);
            r.fault = 1'b0;
            r.last = (i == NJ - 1);
            pending_cmds.push_back(r);
         end
      end else if (cmd == CMD_DAMP) begin
         ctl_mode = MODE_DAMPING;
      end else if (observed_once) begin
         lying = (cmd == CMD_LIE);
         for (int i = 0; i < NJ; i++) begin
            start_pos[i] = obs_pos[i];
            set_pos[i] = obs_pos[i];
            goal_pos[i] = pose_target(lying, i / 3, i % 3);
         end
         prog = 0;
         ctl_mode = MODE_TRAJECTORY;
      end
   endfunction

   task automatic send_word(cmd_type cmd, int limb, int joint, logic [15:0] pos, bit lastw);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {2'b00, pos, 2'(joint), 2'(limb), cmd};
      req_tlast <= lastw;
      do @(posedge clock); while (!req_tready);
      predict_word(cmd, limb, joint, pos, lastw);
      words_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_cmds.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(reg_type idx, int val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= 17'(val);
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_MAX_STEP:  step_lim = val & 16'h1FFF;
         REG_MAX_TRACK: track_lim = val & 16'h1FFF;
         REG_PROG_STEP: prog_inc = val & 17'h1FFFF;
         default:       damp_gain = val & 16'hFFFF;
      endcase
   endtask

   task automatic set_regs(int ms, int mt, int ps, int dg);
      drain();
      write_reg(REG_MAX_STEP, ms);
      write_reg(REG_MAX_TRACK, mt);
      write_reg(REG_PROG_STEP, ps);
      write_reg(REG_DAMP_GAIN, dg);
   endtask

   // noise < 0: fully random positions
   task automatic send_tick(int noise, bit drop_one, bit stray);
      int order[NJ];
      int t, j, cnt, v;
      for (int i = 0; i < NJ; i++) order[i] = i;
      for (int i = NJ - 1; i > 0; i--) begin
         j = $urandom_range(i);
         t = order[i];
         order[i] = order[j];
         order[j] = t;
      end
      cnt = drop_one ? NJ - 1 : NJ;
      for (int i = 0; i < cnt; i++) begin
         if (stray && i == cnt / 2)
            send_word(CMD_SAMPLE, $urandom_range(3), 3, 16'($urandom), 1'b0);
         if (noise < 0) v = $urandom;
         else v = set_pos[order[i]] + $urandom_range(2 * noise) - noise;
         send_word(CMD_SAMPLE, order[i] / 3, order[i] % 3, 16'(v), i == cnt - 1);
      end
   endtask

   task automatic send_cmd(cmd_type c);
      send_word(c, $urandom_range(3), $urandom_range(3), 16'($urandom), 1'($urandom));
   endtask

   task automatic test_directed();
      send_cmd(CMD_STAND);
      send_cmd(CMD_LIE);
      send_word(CMD_SAMPLE, 3, 3, 16'h7FFF, 1'b1);
      send_word(CMD_SAMPLE, 0, 0, 16'h8000, 1'b1);
      send_cmd(CMD_DAMP);
      for (int i = 0; i < NJ; i++)
         send_word(CMD_SAMPLE, i / 3, i % 3,
                   (i % 2) ? 16'h7FFF : 16'h8000, i == NJ - 1);
      send_cmd(CMD_STAND);
      send_cmd(CMD_LIE);
      send_cmd(CMD_DAMP);
   endtask

   task automatic test_random_phase(int budget);
      int r, stop_at;
      stop_at = words_sent + budget;
      while (words_sent < stop_at) begin
         r = $urandom_range(99);
         if (r < 5) send_cmd(CMD_STAND);
         else if (r < 10) send_cmd(CMD_LIE);
         else if (r < 13) send_cmd(CMD_DAMP);
         else if (r < 18) send_tick($urandom_range(50), 1'b1, 1'($urandom));
         else if (r < 23) send_tick(-1, 1'b0, 1'($urandom));
         else if (r < 26) send_word(CMD_SAMPLE, $urandom_range(3), 3, 16'($urandom), 1'b1);
         else if (r < 30) drain();
         else send_tick((r < 60) ? 0 : $urandom_range(1500), 1'b0, r > 95);
      end
   endtask

   task automatic test_phases();
      for (int ph = 0; ph < 7; ph++) begin
         send_idle = (ph < 2) ? 15 : (ph < 4) ? 59 : 0;
         recv_idle = (ph < 2) ? 59 : (ph < 4) ? 15 : 0;
         case (ph)
            0: set_regs(8191, 8191, 65536, 65535);
            1: set_regs(0, 0, 1, 0);
            2: set_regs(300, 2000, 16384, $urandom_range(65535));
            3: set_regs(8191, 0, 0, 1);
            4: set_regs($urandom_range(8191), $urandom_range(8191),
                        $urandom_range(1, 65536), $urandom_range(65535));
            5: set_regs(2048, 8191, 8000, 640);
            default: set_regs(1024, 1024, 655, 640);
         endcase
         test_random_phase(45);
      end
   endtask

   always @(posedge clock) begin
      result_type got, want;
      rsp_tready <= ($urandom_range(99) >= recv_idle);
      if (!reset && ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[1:0], rsp_tdata[3:2], rsp_tdata[19:4], rsp_tdata[35:20],
                rsp_tdata[51:36], rsp_tdata[53:52], rsp_tdata[54], rsp_tdata[55], rsp_tlast};
         if (pending_cmds.size() == 0) begin
            errors++;
            $display("%0t: unexpected word, actual %h", $realtime, got);
         end else begin
            want = pending_cmds.pop_front();
            if (got.out_limb != want.out_limb || got.out_joint != want.out_joint ||
                got.command_position != want.command_position ||
                got.stiffness_gain != want.stiffness_gain ||
                got.velocity_gain != want.velocity_gain || got.action != want.action ||
                got.holding != want.holding || got.fault != want.fault ||
                got.last != want.last) begin
               errors++;
               $display("%0t: mismatch limb/joint/pos/kp/kd/act/hold/fault/last", $realtime);
               $display("   expected %0d %0d %h %h %h %0d %b %b %b", want.out_limb,
                        want.out_joint, want.command_position, want.stiffness_gain,
                        want.velocity_gain, want.action, want.holding, want.fault, want.last);
               $display("   actual   %0d %0d %h %h %h %0d %b %b %b", got.out_limb,
                        got.out_joint, got.command_position, got.stiffness_gain,
                        got.velocity_gain, got.action, got.holding, got.fault, got.last);
            end
         end
      end
   end

   initial begin
      for (int i = 0; i < NJ; i++) begin
         obs_pos[i] = 0;
         start_pos[i] = 0;
         goal_pos[i] = 0;
         set_pos[i] = 0;
      end
      seen_bits = 0;
      prog = 0;
      ctl_mode = MODE_DAMPING;
      lying = 0;
      observed_once = 0;
      step_lim = 1024;
      track_lim = 1024;
      prog_inc = 655;
      damp_gain = 640;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_phases();
      drain();
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
